[rtl/core/i2stx_pkg.sv]
// Shared constants, types and register codes of the I2S/TDM frame serializer.
package i2stx_pkg;

  localparam int MAX_LINES = 8;
  localparam int MAX_SLOTS = 16;
  localparam int SAMPLE_W  = 32;
  localparam int LINE_W    = $clog2(MAX_LINES);
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CLK_W     = 6;
  localparam int ROWS      = 2 * MAX_SLOTS;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int BIT_W     = $clog2(SAMPLE_W);

  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_TICK = 1'b1;

  localparam logic [1:0] REG_FRAME_MODE   = 2'd0;
  localparam logic [1:0] REG_SAMPLE_BITS  = 2'd1;
  localparam logic [1:0] REG_SLOT_CLOCKS  = 2'd2;
  localparam logic [1:0] REG_LINES_IN_USE = 2'd3;

  localparam logic [1:0] MODE_STEREO = 2'd0;
  localparam logic [1:0] MODE_TDM4   = 2'd1;
  localparam logic [1:0] MODE_TDM8   = 2'd2;
  localparam logic [1:0] MODE_TDM16  = 2'd3;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [MAX_LINES-1:0][SAMPLE_W-1:0] row_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [SLOT_W-1:0] slot;
    logic [LINE_W-1:0] line;
    sample_t           data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [SLOT_W-1:0] slot;
  } rd_req_t;

endpackage

[rtl/core/i2stx_in_if.sv]
// Input request channel: sample loads and bit clock ticks.
interface i2stx_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [2:0]  line_index;
  logic [3:0]  slot_index_in;
  logic signed [31:0] sample_value;
  logic        frame_complete;

  modport source (output valid, opcode, line_index, slot_index_in, sample_value,
                  frame_complete, input ready);
  modport sink   (input valid, opcode, line_index, slot_index_in, sample_value,
                  frame_complete, output ready);
endinterface

[rtl/core/i2stx_out_if.sv]
// Output channel: one bit clock word per tick.
interface i2stx_out_if;
  logic       valid;
  logic       ready;
  logic       word_select;
  logic [7:0] line_bits;
  logic [3:0] current_slot;
  logic       frame_end;

  modport source (output valid, word_select, line_bits, current_slot, frame_end,
                  input ready);
  modport sink   (input valid, word_select, line_bits, current_slot, frame_end,
                  output ready);
endinterface

[rtl/core/i2stx_frame_store.sv]
// Two-bank frame memory, one row per bank and slot, one lane per data line.
module i2stx_frame_store (
  input  logic                              clk,
  input  logic                              rst,
  input  i2stx_pkg::wr_req_t                wr,
  input  i2stx_pkg::rd_req_t                rd,
  output i2stx_pkg::row_t                   rd_data,
  output logic [i2stx_pkg::MAX_LINES-1:0]   rd_valid
);

  i2stx_pkg::row_t mem [i2stx_pkg::ROWS];
  logic [i2stx_pkg::MAX_LINES-1:0] vld [i2stx_pkg::ROWS];

  logic [i2stx_pkg::ROW_AW-1:0] waddr;
  logic [i2stx_pkg::ROW_AW-1:0] raddr;

  assign waddr = {wr.bank, wr.slot};
  assign raddr = {rd.bank, rd.slot};

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr][wr.line] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[raddr];
    end
  end

  // lanes never written read as silence
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < i2stx_pkg::ROWS; r++) begin
        vld[r] <= '0;
      end
      rd_valid <= '0;
    end else begin
      if (wr.en) begin
        vld[waddr][wr.line] <= 1'b1;
      end
      if (rd.en) begin
        rd_valid <= vld[raddr];
      end
    end
  end

endmodule

[rtl/core/i2s_tdm_frame_serializer.sv]
// Top level of the I2S/TDM frame serializer: timing, bank control, output stage.
//
//   channel   dir  payload                                              handshake
//   in_chan   in   opcode line_index slot_index_in sample_value          valid/ready
//                  frame_complete
//   out_chan  out  word_select line_bits current_slot frame_end          valid/ready
//   apb       in   frame_mode sample_bits slot_clocks lines_in_use       psel/penable
//
// One request per cycle while in_chan.ready is high. A tick returns its word
// through the frame memory row read and then the output register. Loads return
// nothing. Reset clears the lane valid bits directly; no clearing pass. A
// stalled output holds its register and drops in_chan.ready once the read stage
// behind it is occupied.
module i2s_tdm_frame_serializer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  i2stx_in_if.sink    in_chan,
  i2stx_out_if.source out_chan
);

  logic [1:0] frame_mode;
  logic [5:0] sample_bits;
  logic [6:0] slot_clocks;
  logic [3:0] lines_in_use;

  logic                                active_bank;
  logic                                pending_ready;
  logic [i2stx_pkg::SLOT_W-1:0]        slot_counter;
  logic [i2stx_pkg::CLK_W-1:0]         clock_in_slot;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode   <= i2stx_pkg::MODE_STEREO;
      sample_bits  <= 6'd32;
      slot_clocks  <= 7'd32;
      lines_in_use <= 4'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        i2stx_pkg::REG_FRAME_MODE:   frame_mode   <= pwdata[1:0];
        i2stx_pkg::REG_SAMPLE_BITS:  sample_bits  <= pwdata[5:0];
        i2stx_pkg::REG_SLOT_CLOCKS:  slot_clocks  <= pwdata[6:0];
        i2stx_pkg::REG_LINES_IN_USE: lines_in_use <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      i2stx_pkg::REG_FRAME_MODE:   prdata = {30'd0, frame_mode};
      i2stx_pkg::REG_SAMPLE_BITS:  prdata = {26'd0, sample_bits};
      i2stx_pkg::REG_SLOT_CLOCKS:  prdata = {25'd0, slot_clocks};
      i2stx_pkg::REG_LINES_IN_USE: prdata = {28'd0, lines_in_use};
      default:                     prdata = '0;
    endcase
  end

  // frame timing for the current tick
  logic [4:0] frame_slots;
  logic [6:0] slot_w;
  logic [5:0] bps;
  logic [6:0] nbits;
  logic [3:0] nl;
  logic [6:0] clk7;
  logic       data_on;
  logic       slot_last;
  logic       frame_last;
  logic       ws;
  logic [i2stx_pkg::MAX_LINES-1:0] line_mask;

  always_comb begin
    case (frame_mode)
      i2stx_pkg::MODE_STEREO: frame_slots = 5'd2;
      i2stx_pkg::MODE_TDM4:   frame_slots = 5'd4;
      i2stx_pkg::MODE_TDM8:   frame_slots = 5'd8;
      i2stx_pkg::MODE_TDM16:  frame_slots = 5'd16;
      default:                frame_slots = 5'd16;
    endcase
    if (slot_clocks == 7'd0) begin
      slot_w = 7'd1;
    end else if (slot_clocks > 7'd64) begin
      slot_w = 7'd64;
    end else begin
      slot_w = slot_clocks;
    end
    bps   = (sample_bits > 6'd32) ? 6'd32 : sample_bits;
    nbits = ({1'b0, bps} < slot_w - 7'd1) ? {1'b0, bps} : slot_w - 7'd1;
    nl    = (lines_in_use > 4'(i2stx_pkg::MAX_LINES)) ? 4'(i2stx_pkg::MAX_LINES)
                                                      : lines_in_use;
    for (int l = 0; l < i2stx_pkg::MAX_LINES; l++) begin
      line_mask[l] = (4'(l) < nl);
    end
    clk7       = {1'b0, clock_in_slot};
    data_on    = (clock_in_slot != '0) && (clk7 <= nbits);
    slot_last  = (clk7 + 7'd1) >= slot_w;
    frame_last = slot_last && (({1'b0, slot_counter} + 5'd1) >= frame_slots);
    if (frame_mode == i2stx_pkg::MODE_STEREO) begin
      ws = (slot_counter != '0);
    end else begin
      ws = (slot_counter == '0) && (clock_in_slot == '0);
    end
  end

  // handshake and pipeline control
  logic s1_valid;
  logic out_valid;
  logic out_free;
  logic in_ready;
  logic in_acc;
  logic tick_acc;
  logic load_acc;

  assign out_free = !out_valid || out_chan.ready;
  assign in_ready = !s1_valid || out_free;
  assign in_acc   = in_chan.valid && in_ready;
  assign tick_acc = in_acc && (in_chan.opcode == i2stx_pkg::OPC_TICK);
  assign load_acc = in_acc && (in_chan.opcode == i2stx_pkg::OPC_LOAD);
  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank   <= 1'b0;
      pending_ready <= 1'b0;
      slot_counter  <= '0;
      clock_in_slot <= '0;
    end else begin
      if (load_acc && in_chan.frame_complete) begin
        pending_ready <= 1'b1;
      end
      if (tick_acc) begin
        if (slot_last) begin
          clock_in_slot <= '0;
          if (frame_last) begin
            slot_counter <= '0;
            if (pending_ready) begin
              active_bank   <= ~active_bank;
              pending_ready <= 1'b0;
            end
          end else begin
            slot_counter <= slot_counter + 1'b1;
          end
        end else begin
          clock_in_slot <= clock_in_slot + 1'b1;
        end
      end
    end
  end

  i2stx_pkg::wr_req_t              wr;
  i2stx_pkg::rd_req_t              rd;
  i2stx_pkg::row_t                 rd_data;
  logic [i2stx_pkg::MAX_LINES-1:0] rd_valid;

  assign wr.en   = load_acc;
  assign wr.bank = ~active_bank;
  assign wr.slot = in_chan.slot_index_in;
  assign wr.line = in_chan.line_index;
  assign wr.data = in_chan.sample_value;
  assign rd.en   = tick_acc;
  assign rd.bank = active_bank;
  assign rd.slot = slot_counter;

  i2stx_frame_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd       (rd),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  // read stage: tick metadata waits beside the memory output
  logic                              s1_ws;
  logic                              s1_frame_end;
  logic [i2stx_pkg::SLOT_W-1:0]      s1_slot;
  logic [i2stx_pkg::BIT_W-1:0]       s1_bsel;
  logic [i2stx_pkg::MAX_LINES-1:0]   s1_lanes;
  logic [i2stx_pkg::MAX_LINES-1:0]   s1_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_acc) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_ws        <= ws;
      s1_frame_end <= frame_last;
      s1_slot      <= slot_counter;
      s1_bsel      <= ~(clock_in_slot[i2stx_pkg::BIT_W-1:0] - 1'b1);
      s1_lanes     <= data_on ? line_mask : '0;
    end
  end

  always_comb begin
    for (int l = 0; l < i2stx_pkg::MAX_LINES; l++) begin
      s1_bits[l] = s1_lanes[l] && rd_valid[l] && rd_data[l][s1_bsel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_chan.word_select  <= s1_ws;
      out_chan.line_bits    <= s1_bits;
      out_chan.current_slot <= s1_slot;
      out_chan.frame_end    <= s1_frame_end;
    end
  end

  assign out_chan.valid = out_valid;

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |-> !in_chan.ready)
    else $error("read stage overrun");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    tick_acc && frame_last |=> slot_counter == '0 && clock_in_slot == '0)
    else $error("counters not cleared at frame end");

  a_clock_step: assert property (@(posedge clk) disable iff (rst)
    tick_acc && !slot_last |=> clock_in_slot == $past(clock_in_slot) + 1'b1)
    else $error("bit clock counter skipped");

  a_swap_at_end: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && active_bank != $past(active_bank)
      |-> $past(tick_acc && frame_last && pending_ready))
    else $error("bank swap outside frame end");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_slot))
    else $error("read stage lost a stalled tick");

endmodule
